// ===== src/pomodoro_phase_timer_core_assert.svh =====
// Assertion macros for the pomodoro phase timer state logic.
`ifndef POMODORO_PHASE_TIMER_CORE_ASSERT_SVH
`define POMODORO_PHASE_TIMER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ppt_pkg.sv =====
// Types, constants and helper functions for the pomodoro phase timer.
package ppt_pkg;

	// Field widths.
	localparam int unsigned TIME_W   = 63;
	localparam int unsigned STEPS_W  = 8;
	localparam int unsigned SECS_W   = 13;
	localparam int unsigned SESS_W   = 16;
	localparam int unsigned PRESET_W = 2;

	// Stream widths: input tdata carries time and preset steps, tuser the command.
	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 40;

	// Number of presets; a power of two, so the wrap is a mask.
	localparam int unsigned PRESET_COUNT = 4;

	// One second is TICKS_ODD << TICKS_SHIFT microseconds (1000000).
	localparam int unsigned TICKS_SHIFT = 6;
	localparam int unsigned TICKS_ODD   = 15625;

	// Differences at or above 2^NEAR_W are longer than any phase.
	localparam int unsigned NEAR_W   = 33;
	localparam int unsigned SCALED_W = NEAR_W - TICKS_SHIFT;

	// Reciprocal of TICKS_ODD, exact for every SCALED_W-bit dividend.
	localparam int unsigned RECIP_SHIFT = SCALED_W + 14;
	localparam int unsigned RECIP_W     = 28;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(TICKS_ODD) - 64'd1) / 64'(TICKS_ODD);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam int unsigned PROD_W = SCALED_W + RECIP_W;
	localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;

	// Longest phase in seconds.
	localparam logic [SECS_W-1:0] PHASE_MAX = 13'd5400;

	// Phase lengths in seconds, per preset.
	localparam logic [SECS_W-1:0] WORK_SECS [PRESET_COUNT] =
		'{13'd1500, 13'd3000, 13'd3600, 13'd5400};
	localparam logic [SECS_W-1:0] BREAK_SECS [PRESET_COUNT] =
		'{13'd300, 13'd600, 13'd1200, 13'd1200};

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_PAUSE  = 2'd2,
		CMD_SELECT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RUN_READY   = 2'd0,
		RUN_RUNNING = 2'd1,
		RUN_PAUSED  = 2'd2
	} run_state_t;

	typedef enum logic [1:0] {
		TOG_NONE    = 2'd0,
		TOG_STARTED = 2'd1,
		TOG_RESUMED = 2'd2,
		TOG_PAUSED  = 2'd3
	} toggle_t;

	// One command, last member in the lowest bits.
	typedef struct packed {
		logic [STEPS_W-1:0] preset_steps;
		logic [TIME_W-1:0]  now_time_us;
		cmd_t               cmd;
	} item_t;

	// One result, members listed from the highest tdata bit down.
	typedef struct packed {
		logic [SESS_W-1:0]   sessions;
		logic [SECS_W-1:0]   seconds_left;
		logic [PRESET_W-1:0] preset;
		logic                brk;
		run_state_t          run_state;
		logic                tick_advanced;
		toggle_t             toggle_outcome;
	} result_t;

	// Phase length for the given phase and preset.
	function automatic logic [SECS_W-1:0] phase_seconds(logic brk, logic [PRESET_W-1:0] idx);
		return brk ? BREAK_SECS[idx] : WORK_SECS[idx];
	endfunction

	// Whole seconds to microseconds: 15625 = 2^14 - 2^9 - 2^8 + 2^3 + 1, then << 6.
	function automatic logic [NEAR_W-1:0] sec_ticks(logic [SECS_W-1:0] secs);
		logic [NEAR_W-1:0] w;
		w = NEAR_W'(secs);
		return ((w << 14) - (w << 9) - (w << 8) + (w << 3) + w) << TICKS_SHIFT;
	endfunction

endpackage

// ===== src/ppt_in_stage.sv =====
// Input register stage for the pomodoro phase timer command stream.
module ppt_in_stage
	import ppt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	// The stage takes a new command when empty or when its current one moves on.
	assign in_ready = !valid_s1 || advance;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Command payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== src/ppt_state.sv =====
// Timer state registers and the single-pass command update logic.
`include "pomodoro_phase_timer_core_assert.svh"

module ppt_state
	import ppt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t result
);

	run_state_t          run_q, run_d;
	logic                in_break_q, in_break_d;
	logic [PRESET_W-1:0] preset_q, preset_d;
	logic [SECS_W-1:0]   secs_q, secs_d;
	logic [SESS_W-1:0]   sessions_q, sessions_d;
	logic [TIME_W-1:0]   mark_q, mark_d;

	logic                borrow;
	logic [TIME_W-1:0]   diff;
	logic                far;
	logic [SCALED_W-1:0] scaled;
	logic [PROD_W-1:0]   prod;
	logic [QUOT_W-1:0]   quot;
	logic                expire;
	logic                elapsed;
	logic                tick_live;
	logic                advanced;
	toggle_t             toggle;

	// Whole seconds since the mark; anything past NEAR_W bits ends any phase.
	always_comb begin : tick_math
		{borrow, diff} = {1'b0, item.now_time_us} - {1'b0, mark_q};
		far     = |diff[TIME_W-1:NEAR_W];
		scaled  = diff[NEAR_W-1:TICKS_SHIFT];
		prod    = PROD_W'(scaled) * PROD_W'(RECIP);
		quot    = prod[RECIP_SHIFT +: QUOT_W];
		expire  = far || (quot >= QUOT_W'(secs_q));
		elapsed = !borrow && (far || (quot != '0));
	end

	assign tick_live = (item.cmd == CMD_TICK) && (run_q == RUN_RUNNING) && elapsed;

	// Next run state.
	always_comb begin : run_next
		run_d = run_q;
		unique case (item.cmd)
			CMD_TICK: begin
				if (tick_live && expire) begin
					run_d = RUN_READY;
				end
			end
			CMD_TOGGLE: begin
				run_d = (run_q == RUN_RUNNING) ? RUN_PAUSED : RUN_RUNNING;
			end
			CMD_PAUSE: begin
				if (run_q == RUN_RUNNING) begin
					run_d = RUN_PAUSED;
				end
			end
			CMD_SELECT: begin
				run_d = run_q;
			end
		endcase
	end

	// Phase, preset, countdown, session count and second mark.
	always_comb begin : data_next
		in_break_d = in_break_q;
		preset_d   = preset_q;
		secs_d     = secs_q;
		sessions_d = sessions_q;
		mark_d     = mark_q;
		advanced   = 1'b0;
		toggle     = TOG_NONE;
		unique case (item.cmd)
			CMD_TICK: begin
				if (tick_live) begin
					advanced = 1'b1;
					if (expire) begin
						// The mark is not needed again until the next start.
						in_break_d = !in_break_q;
						if (!in_break_q && (sessions_q != '1)) begin
							sessions_d = sessions_q + 1'b1;
						end
						secs_d = phase_seconds(!in_break_q, preset_q);
					end else begin
						secs_d = secs_q - quot[SECS_W-1:0];
						mark_d = mark_q + TIME_W'(sec_ticks(quot[SECS_W-1:0]));
					end
				end
			end
			CMD_TOGGLE: begin
				if (run_q == RUN_RUNNING) begin
					toggle = TOG_PAUSED;
				end else begin
					toggle = (run_q == RUN_READY) ? TOG_STARTED : TOG_RESUMED;
					mark_d = item.now_time_us;
				end
			end
			CMD_PAUSE: begin
				mark_d = mark_q;
			end
			CMD_SELECT: begin
				// Preset count is a power of two, so floor modulo is a mask.
				if (run_q == RUN_READY) begin
					preset_d = preset_q + item.preset_steps[PRESET_W-1:0];
					secs_d   = phase_seconds(in_break_q, preset_d);
				end
			end
		endcase
	end

	// Result reflects the state after the command.
	always_comb begin : result_build
		result.toggle_outcome = toggle;
		result.tick_advanced  = advanced;
		result.run_state      = run_d;
		result.brk            = in_break_d;
		result.preset         = preset_d;
		result.seconds_left   = secs_d;
		result.sessions       = sessions_d;
	end

	// State registers, updated once per command transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= RUN_READY;
			in_break_q <= 1'b0;
			preset_q   <= '0;
			secs_q     <= WORK_SECS[0];
			sessions_q <= '0;
			mark_q     <= '0;
		end else if (en) begin
			run_q      <= run_d;
			in_break_q <= in_break_d;
			preset_q   <= preset_d;
			secs_q     <= secs_d;
			sessions_q <= sessions_d;
			mark_q     <= mark_d;
		end
	end

	`PPT_ASSERT_SAME(a_secs_range, clk, arst_n, 1'b1,
		(secs_q != '0) && (secs_q <= PHASE_MAX), "seconds left out of range")
	`PPT_ASSERT_NEXT(a_sessions_mono, clk, arst_n, en,
		sessions_q >= $past(sessions_q), "session count went down")
	`PPT_ASSERT_NEXT(a_select_locked, clk, arst_n,
		en && (item.cmd == CMD_SELECT) && (run_q != RUN_READY),
		$stable(preset_q), "preset changed while not ready")
	`PPT_ASSERT_NEXT(a_expire_flips, clk, arst_n, en && tick_live && expire,
		(run_q == RUN_READY) && (in_break_q != $past(in_break_q)),
		"expiry did not flip the phase and return to ready")

endmodule

// ===== src/ppt_out_stage.sv =====
// Result register stage for the pomodoro phase timer result stream.
module ppt_out_stage
	import ppt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_in,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result_s2
);

	logic valid_s2;

	// A new result may enter when empty or when the held one leaves.
	assign can_load  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result_in;
		end
	end

endmodule

// ===== src/pomodoro_phase_timer_core.sv =====
// A command enters the input register, then its result enters the result register when that can load.
// Throughput: one command per cycle while m_tready is high; the update is a single pass between them.
// A stalled result holds in the result register while the next command waits in the input one.
// Reset (arst_n low, asynchronous): both stages empty, ready work phase of preset zero,
// 1500 seconds left, no sessions, second mark zero.
module pomodoro_phase_timer_core
	import ppt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// now_time_us[62:0], preset_steps[70:63], zero fill [71]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// toggle_outcome[1:0], tick_advanced[2], run_state_out[4:3], break_phase_out[5],
	// preset_out[7:6], seconds_left_out[20:8], sessions_out[36:21], zero fill [39:37]
	output logic [M_TDATA_W-1:0] m_tdata
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    can_load;
	logic    advance;
	result_t result_next;
	result_t result_s2;

	// Unpack the incoming command.
	always_comb begin : unpack
		in_item.cmd          = cmd_t'(s_tuser);
		in_item.now_time_us  = s_tdata[TIME_W-1:0];
		in_item.preset_steps = s_tdata[TIME_W +: STEPS_W];
	end

	// A held command is processed when the result register can take its result.
	assign advance = valid_s1 && can_load;

	ppt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ppt_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (result_next)
	);

	ppt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result_in (result_next),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_s2 (result_s2)
	);

	// Pack the result, zero filled to whole bytes.
	assign m_tdata = M_TDATA_W'(result_s2);

endmodule

// ===== bench/ppt_timer_checker.sv =====
// Checker for the pomodoro phase timer: watches both streams, predicts each result and compares it.
module ppt_timer_checker
	import ppt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// now_time_us[62:0], preset_steps[70:63], zero fill [71]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// toggle_outcome[1:0], tick_advanced[2], run_state_out[4:3], break_phase_out[5],
	// preset_out[7:6], seconds_left_out[20:8], sessions_out[36:21], zero fill [39:37]
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   errors,
	output int                   waiting
);

	localparam longint unsigned US_PER_SEC = 64'd1000000;
	localparam logic [SESS_W-1:0] SESSIONS_CAP = '1;

	// Phase lengths in minutes, indexed by preset.
	int unsigned focus_minutes [PRESET_COUNT] = '{25, 50, 60, 90};
	int unsigned rest_minutes [PRESET_COUNT] = '{5, 10, 20, 20};

	// Timer state as the checker sees it.
	run_state_t          run_st;
	logic                brk_st;
	logic [PRESET_W-1:0] preset_st;
	logic [SECS_W-1:0]   secs_st;
	logic [SESS_W-1:0]   sess_st;
	logic [TIME_W-1:0]   mark_st;

	// Results owed by the block, oldest first.
	result_t owed_results [$];

	function automatic logic [SECS_W-1:0] phase_len(logic rest, logic [PRESET_W-1:0] p);
		return SECS_W'((rest ? rest_minutes[p] : focus_minutes[p]) * 60);
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
	endtask

	// Applies one command to the timer state and returns the state after it.
	task automatic apply_timer_cmd(input cmd_t c, input logic [TIME_W-1:0] now,
		input logic signed [STEPS_W-1:0] steps, output result_t r);
		longint unsigned whole_secs;
		int idx;
		r = '0;
		case (c)
			CMD_TICK: begin
				if (run_st == RUN_RUNNING && now >= mark_st) begin
					whole_secs = (64'(now) - 64'(mark_st)) / US_PER_SEC;
					if (whole_secs != 0) begin
						r.tick_advanced = 1'b1;
						mark_st = TIME_W'(64'(mark_st) + whole_secs * US_PER_SEC);
						if (whole_secs >= 64'(secs_st)) begin
							// The phase has run out: flip it and go back to ready.
							if (!brk_st) begin
								if (sess_st != SESSIONS_CAP)
									sess_st++;
								brk_st = 1'b1;
							end else begin
								brk_st = 1'b0;
							end
							secs_st = phase_len(brk_st, preset_st);
							run_st = RUN_READY;
						end else begin
							secs_st = secs_st - SECS_W'(whole_secs);
						end
					end
				end
			end
			CMD_TOGGLE: begin
				if (run_st == RUN_RUNNING) begin
					run_st = RUN_PAUSED;
					r.toggle_outcome = TOG_PAUSED;
				end else begin
					r.toggle_outcome = (run_st == RUN_READY) ? TOG_STARTED : TOG_RESUMED;
					run_st = RUN_RUNNING;
					mark_st = now;
				end
			end
			CMD_PAUSE: begin
				if (run_st == RUN_RUNNING)
					run_st = RUN_PAUSED;
			end
			CMD_SELECT: begin
				if (run_st == RUN_READY) begin
					// Floor modulo of the signed sum.
					idx = (int'(preset_st) + int'(steps)) % int'(PRESET_COUNT);
					if (idx < 0)
						idx += int'(PRESET_COUNT);
					preset_st = PRESET_W'(idx);
					secs_st = phase_len(brk_st, preset_st);
				end
			end
		endcase
		r.run_state = run_st;
		r.brk = brk_st;
		r.preset = preset_st;
		r.seconds_left = secs_st;
		r.sessions = sess_st;
	endtask

	// Retire results first, then predict the command taken at the same edge.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			run_st = RUN_READY;
			brk_st = 1'b0;
			preset_st = '0;
			secs_st = phase_len(1'b0, '0);
			sess_st = '0;
			mark_st = '0;
			owed_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (owed_results.size() == 0) begin
					flag_mismatch("result with no command pending", 64'(m_tdata), 64'd0);
				end else begin
					want = owed_results.pop_front();
					if (got.toggle_outcome !== want.toggle_outcome)
						flag_mismatch("toggle_outcome", 64'(got.toggle_outcome),
							64'(want.toggle_outcome));
					if (got.tick_advanced !== want.tick_advanced)
						flag_mismatch("tick_advanced", 64'(got.tick_advanced),
							64'(want.tick_advanced));
					if (got.run_state !== want.run_state)
						flag_mismatch("run_state_out", 64'(got.run_state),
							64'(want.run_state));
					if (got.brk !== want.brk)
						flag_mismatch("break_phase_out", 64'(got.brk), 64'(want.brk));
					if (got.preset !== want.preset)
						flag_mismatch("preset_out", 64'(got.preset), 64'(want.preset));
					if (got.seconds_left !== want.seconds_left)
						flag_mismatch("seconds_left_out", 64'(got.seconds_left),
							64'(want.seconds_left));
					if (got.sessions !== want.sessions)
						flag_mismatch("sessions_out", 64'(got.sessions),
							64'(want.sessions));
				end
			end
			if (s_tvalid && s_tready) begin
				apply_timer_cmd(cmd_t'(s_tuser), s_tdata[TIME_W-1:0],
					$signed(s_tdata[TIME_W +: STEPS_W]), want);
				owed_results.push_back(want);
			end
		end
		waiting = owed_results.size();
	end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the pomodoro phase timer: clock, reset, command stimulus and verdict.
module tb_top;
	import ppt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam longint unsigned SEC_US = 64'd1000000;
	localparam logic [TIME_W-1:0] TIME_TOP = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	int errors;
	int waiting;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs = 0;
	int unsigned cycles = 0;
	longint unsigned wall_us = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pomodoro_phase_timer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ppt_timer_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.waiting  (waiting)
	);

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	initial begin : result_side
		int hold_cnt;
		int hold_done;
		hold_cnt = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_done) begin
				hold_done = hold_reqs;
				hold_cnt = 90;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one command and returns at the edge where it transfers; valid stays up.
	task automatic push_cmd(cmd_t c, logic [TIME_W-1:0] t, logic [STEPS_W-1:0] st);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {1'b0, st, t};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stops offering and waits until every result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (waiting == 0);
		@(posedge clk);
	endtask

	// Mostly plausible command streams on a forward-moving clock, with some noise.
	task automatic run_random(int n);
		int roll;
		longint unsigned jump;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				push_cmd(cmd_t'($urandom_range(3)), TIME_W'({$urandom, $urandom}),
					STEPS_W'($urandom));
			end else if (roll < 58) begin
				roll = $urandom_range(99);
				if (roll < 55)
					jump = 64'($urandom_range(0, 2500000));
				else if (roll < 82)
					jump = 64'($urandom_range(0, 600)) * SEC_US
						+ 64'($urandom_range(0, 999999));
				else if (roll < 94)
					jump = 64'($urandom_range(300, 6000)) * SEC_US
						+ 64'($urandom_range(0, 999999));
				else
					jump = 0;
				if (roll >= 97 && wall_us > 64'd5000000) begin
					// A timestamp from the past.
					push_cmd(CMD_TICK, TIME_W'(wall_us - 64'($urandom_range(1, 5000000))),
						STEPS_W'($urandom));
				end else begin
					wall_us += jump;
					push_cmd(CMD_TICK, TIME_W'(wall_us), STEPS_W'($urandom));
				end
			end else if (roll < 78) begin
				wall_us += 64'($urandom_range(0, 999999));
				push_cmd(CMD_TOGGLE, TIME_W'(wall_us), STEPS_W'($urandom));
			end else if (roll < 86) begin
				push_cmd(CMD_PAUSE, TIME_W'({$urandom, $urandom}), STEPS_W'($urandom));
			end else begin
				push_cmd(CMD_SELECT, TIME_W'({$urandom, $urandom}), STEPS_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// First setting: sender idles lightly, receiver heavily.
		send_idle_pct = 21;
		recv_idle_pct = 70;

		// Directed commands: preset wrap extremes, each command but select in every state,
		// sub-second and backwards ticks, top of the time range, long gap and exact expiry.
		push_cmd(CMD_TICK, '0, 8'h00);
		push_cmd(CMD_SELECT, '0, 8'h80);
		push_cmd(CMD_SELECT, '0, 8'h7F);
		push_cmd(CMD_SELECT, '0, 8'hFF);
		push_cmd(CMD_SELECT, '0, 8'h01);
		push_cmd(CMD_SELECT, '0, 8'hFD);
		push_cmd(CMD_PAUSE, '0, 8'h00);
		push_cmd(CMD_TOGGLE, TIME_W'(64'd5000000), 8'h00);
		push_cmd(CMD_SELECT, '0, 8'h01);
		push_cmd(CMD_TICK, TIME_W'(64'd5999999), 8'h00);
		push_cmd(CMD_TICK, TIME_W'(64'd6000000), 8'h00);
		push_cmd(CMD_TICK, TIME_W'(64'd1000), 8'h00);
		push_cmd(CMD_PAUSE, '0, 8'h00);
		push_cmd(CMD_PAUSE, '0, 8'h00);
		push_cmd(CMD_TICK, TIME_W'(64'd9000000), 8'h00);
		push_cmd(CMD_TOGGLE, TIME_TOP - TIME_W'(2500000), 8'h00);
		push_cmd(CMD_TICK, TIME_TOP, 8'h00);
		push_cmd(CMD_TOGGLE, TIME_TOP, 8'h00);
		push_cmd(CMD_TOGGLE, TIME_W'(64'd1000), 8'h00);
		push_cmd(CMD_TICK, TIME_W'(64'd5000001000), 8'h00);
		push_cmd(CMD_SELECT, '0, 8'h02);
		push_cmd(CMD_TOGGLE, TIME_W'(64'd7000000000), 8'h00);
		push_cmd(CMD_TICK, TIME_W'(64'd7000000000 + 64'd1200 * SEC_US), 8'h00);
		push_cmd(CMD_SELECT, '0, 8'hFE);

		wall_us = {$urandom, $urandom} >> 3;
		run_random(530);
		wait_drained();

		// Second setting: roles swapped, opened by a long receiver hold-off.
		send_idle_pct = 70;
		recv_idle_pct = 21;
		hold_reqs++;
		run_random(40);
		wait_drained();
		run_random(500);
		wait_drained();

		// Third setting: no idling at all.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(580);

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
